/* sv/generation_tagged_request_tracker_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the generation tagged request tracker
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GENERATION_TAGGED_REQUEST_TRACKER_MACROS_SVH
`define GENERATION_TAGGED_REQUEST_TRACKER_MACROS_SVH

// Same-cycle implication
`define GTRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GTRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gtrt_pkg.sv */
// ----------------------------------------------------------------------------
// gtrt_pkg
// Request kinds, phase codes and shared types of the request tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtrt_pkg;

  // Request kinds
  localparam logic [2:0] REQ_SCHEDULE   = 3'd0;
  localparam logic [2:0] REQ_DISPATCH   = 3'd1;
  localparam logic [2:0] REQ_EXPIRE     = 3'd2;
  localparam logic [2:0] REQ_ACCEPT     = 3'd3;
  localparam logic [2:0] REQ_INVALIDATE = 3'd4;
  localparam logic [2:0] REQ_REMOVE     = 3'd5;

  // Phases of the active request
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_SCHEDULED = 2'd1;
  localparam logic [1:0] PH_AWAITING  = 2'd2;
  localparam logic [1:0] PH_DISPLAYED = 2'd3;

  localparam int unsigned REQ_BITS   = 3;
  localparam int unsigned PHASE_BITS = 2;

  // Status of a slot table sweep
  typedef struct packed {
    logic done;   // last slot compared this cycle
    logic hit;    // a valid slot holds the target
    logic free;   // a free slot was seen
  } scan_stat_t;

endpackage

/* sv/gtrt_ram.sv */
// ----------------------------------------------------------------------------
// gtrt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtrt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/gtrt_scan.sv */
// ----------------------------------------------------------------------------
// gtrt_scan
// Sweeps the slot RAM one entry per cycle, finding the slot that holds a
// target and the lowest free slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtrt_scan #(
  parameter int unsigned SLOTS       = 8,
  parameter int unsigned TARGET_BITS = 16,
  parameter int unsigned GEN_BITS    = 32,
  localparam int unsigned IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TARGET_BITS-1:0] target_i,
  input  logic [SLOTS-1:0]       slot_valid_i,
  // RAM read side
  output logic                   rd_en_o,
  output logic [IDX_W-1:0]       rd_addr_o,
  input  logic [TARGET_BITS-1:0] rd_target_i,
  input  logic [GEN_BITS-1:0]    rd_gen_i,
  // Results, held until the next start
  output gtrt_pkg::scan_stat_t   stat_o,
  output logic [IDX_W-1:0]       hit_idx_o,
  output logic [GEN_BITS-1:0]    hit_gen_o,
  output logic [IDX_W-1:0]       free_idx_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic                active_q;
  logic [IDX_W-1:0]    idx_q;
  logic                cmp_vld_q;
  logic                cmp_last_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                hit_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [GEN_BITS-1:0] hit_gen_q;
  logic                free_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic                match;
  logic                free_seen;

  // Read issue
  assign rd_en_o   = active_q;
  assign rd_addr_o = idx_q;

  // Compare one returned entry; free check on the issued index
  assign match     = cmp_vld_q && slot_valid_i[cmp_idx_q] && (rd_target_i == target_i);
  assign free_seen = active_q && !slot_valid_i[idx_q];

  // Sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      cmp_idx_q  <= '0;
    end else begin
      cmp_vld_q  <= active_q;
      cmp_idx_q  <= idx_q;
      cmp_last_q <= active_q && (idx_q == LAST_IDX);
      if (start_i) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (active_q) begin
        if (idx_q == LAST_IDX) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Hit and free capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (start_i) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (match && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (free_seen && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  // Captured payload
  always_ff @(posedge clk_i) begin
    if (match && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_gen_q <= rd_gen_i;
    end
    if (free_seen && !free_q) begin
      free_idx_q <= idx_q;
    end
  end

  assign stat_o.done = cmp_vld_q && cmp_last_q;
  assign stat_o.hit  = hit_q;
  assign stat_o.free = free_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_gen_o   = hit_gen_q;
  assign free_idx_o  = free_idx_q;

endmodule

/* sv/generation_tagged_request_tracker.sv */
// ----------------------------------------------------------------------------
// generation_tagged_request_tracker
// Phase, target and generation tracking of one request, with a slot table
// of outstanding dispatched generations held in RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. Schedule, invalidate and unknown kinds
// go from acceptance straight to the apply state; dispatch, expire, accept
// and remove target first sweep the slot RAM, which returns one entry per
// cycle on its single read port. Applying a request waits while an earlier
// result is still unaccepted in the output register. A new request is taken
// in the cycle after the previous one has been applied, even while its
// result still waits in the output register. Slot valid bits are flip-flops
// cleared by reset, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generation_tagged_request_tracker #(
  parameter int unsigned SLOTS       = 8,
  parameter int unsigned TARGET_BITS = 16,
  parameter int unsigned GEN_BITS    = 32,
  localparam int unsigned IN_F       = TARGET_BITS + GEN_BITS,
  localparam int unsigned IN_W       = ((IN_F + 7) / 8) * 8,
  localparam int unsigned OUT_F      = 2 + GEN_BITS + gtrt_pkg::PHASE_BITS + TARGET_BITS,
  localparam int unsigned OUT_W      = ((OUT_F + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,   // target_id, generation_tag
  input  logic [gtrt_pkg::REQ_BITS-1:0] s_axis_tuser,   // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata    // ok, generation_now, phase_now,
                                                        // active_target_now, table_full
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RAM_W = TARGET_BITS + GEN_BITS;
  localparam int unsigned TGT_LO = 0;
  localparam int unsigned GEN_LO = TARGET_BITS;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [2:0]             kind_q;
  logic [TARGET_BITS-1:0] tgt_q;
  logic [GEN_BITS-1:0]    tag_q;

  logic [gtrt_pkg::PHASE_BITS-1:0] phase_q, phase_d;
  logic [GEN_BITS-1:0]    gen_q, gen_d;
  logic [TARGET_BITS-1:0] at_q, at_d;
  logic [SLOTS-1:0]       valid_q, valid_d;

  logic                   m_valid_q;
  logic [OUT_W-1:0]       m_data_q, m_data_d;

  logic                   in_fire;
  logic                   apply_fire;
  logic                   needs_scan;
  logic [2:0]             in_kind;
  logic                   ok;
  logic                   full;
  logic                   ram_we;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [RAM_W-1:0]       rd_data;
  gtrt_pkg::scan_stat_t   stat;
  logic [IDX_W-1:0]       hit_idx;
  logic [GEN_BITS-1:0]    hit_gen;
  logic [IDX_W-1:0]       free_idx;

  // Input handshake
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_kind       = s_axis_tuser;
  assign needs_scan    = (in_kind == gtrt_pkg::REQ_DISPATCH) ||
                         (in_kind == gtrt_pkg::REQ_EXPIRE)   ||
                         (in_kind == gtrt_pkg::REQ_ACCEPT)   ||
                         (in_kind == gtrt_pkg::REQ_REMOVE);
  assign apply_fire    = (state_q == ST_APPLY) && (!m_valid_q || m_axis_tready);

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_kind;
      tgt_q  <= s_axis_tdata[TGT_LO +: TARGET_BITS];
      tag_q  <= s_axis_tdata[GEN_LO +: GEN_BITS];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = needs_scan ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (stat.done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Slot table storage: {generation, target} per slot
  gtrt_ram #(
    .WIDTH(RAM_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i ({tag_q, tgt_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Slot sweep
  gtrt_scan #(
    .SLOTS(SLOTS),
    .TARGET_BITS(TARGET_BITS),
    .GEN_BITS(GEN_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire && needs_scan),
    .target_i    (tgt_q),
    .slot_valid_i(valid_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_target_i (rd_data[TARGET_BITS-1:0]),
    .rd_gen_i    (rd_data[TARGET_BITS +: GEN_BITS]),
    .stat_o      (stat),
    .hit_idx_o   (hit_idx),
    .hit_gen_o   (hit_gen),
    .free_idx_o  (free_idx)
  );

  // Event handling
  always_comb begin
    phase_d = phase_q;
    gen_d   = gen_q;
    at_d    = at_q;
    valid_d = valid_q;
    ok      = 1'b0;
    full    = 1'b0;
    ram_we  = 1'b0;
    case (kind_q)
      gtrt_pkg::REQ_SCHEDULE: begin
        at_d    = tgt_q;
        phase_d = gtrt_pkg::PH_SCHEDULED;
        gen_d   = gen_q + 1'b1;
        ok      = 1'b1;
      end
      gtrt_pkg::REQ_DISPATCH: begin
        if ((phase_q == gtrt_pkg::PH_SCHEDULED) && (tag_q == gen_q) &&
            (tgt_q == at_q) && !stat.hit) begin
          if (!stat.free) begin
            full = 1'b1;
          end else begin
            ram_we            = apply_fire;
            valid_d[free_idx] = 1'b1;
            phase_d           = gtrt_pkg::PH_AWAITING;
            ok                = 1'b1;
          end
        end
      end
      gtrt_pkg::REQ_EXPIRE: begin
        if (stat.hit && (hit_gen == tag_q)) begin
          valid_d[hit_idx] = 1'b0;
          ok               = 1'b1;
          if ((phase_q == gtrt_pkg::PH_AWAITING) && (tgt_q == at_q) && (tag_q == gen_q)) begin
            gen_d   = gen_q + 1'b1;
            at_d    = '0;
            phase_d = gtrt_pkg::PH_IDLE;
          end
        end
      end
      gtrt_pkg::REQ_ACCEPT: begin
        if (stat.hit) begin
          valid_d[hit_idx] = 1'b0;
          if ((phase_q == gtrt_pkg::PH_AWAITING) && (tgt_q == at_q) && (hit_gen == gen_q)) begin
            phase_d = gtrt_pkg::PH_DISPLAYED;
            ok      = 1'b1;
          end
        end
      end
      gtrt_pkg::REQ_INVALIDATE: begin
        if ((phase_q != gtrt_pkg::PH_IDLE) && (tgt_q == at_q)) begin
          gen_d   = gen_q + 1'b1;
          at_d    = '0;
          phase_d = gtrt_pkg::PH_IDLE;
          ok      = 1'b1;
        end
      end
      gtrt_pkg::REQ_REMOVE: begin
        if (stat.hit) begin
          valid_d[hit_idx] = 1'b0;
          ok               = 1'b1;
        end
        if (at_q == tgt_q) begin
          gen_d   = gen_q + 1'b1;
          at_d    = '0;
          phase_d = gtrt_pkg::PH_IDLE;
          ok      = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Result word
  assign m_data_d = OUT_W'({full, at_d, phase_d, gen_d, ok});

  // Tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= gtrt_pkg::PH_IDLE;
      gen_q   <= '0;
      at_q    <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (apply_fire) begin
        phase_q <= phase_d;
        gen_q   <= gen_d;
        at_q    <= at_d;
        valid_q <= valid_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (apply_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* sv/gtrt_checker.sv */
// ----------------------------------------------------------------------------
// gtrt_checker
// Port-level checks of the request tracker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generation_tagged_request_tracker_macros.svh"

module gtrt_checker #(
  parameter int unsigned TARGET_BITS = 16,
  parameter int unsigned GEN_BITS    = 32,
  parameter int unsigned OUT_W       = 56
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned PH_LO   = 1 + GEN_BITS;
  localparam int unsigned AT_LO   = PH_LO + gtrt_pkg::PHASE_BITS;
  localparam int unsigned FULL_AT = AT_LO + TARGET_BITS;

  logic                            r_ok;
  logic [gtrt_pkg::PHASE_BITS-1:0] r_phase;
  logic [TARGET_BITS-1:0]          r_target;
  logic                            r_full;

  assign r_ok     = m_axis_tdata[0];
  assign r_phase  = m_axis_tdata[PH_LO +: gtrt_pkg::PHASE_BITS];
  assign r_target = m_axis_tdata[AT_LO +: TARGET_BITS];
  assign r_full   = m_axis_tdata[FULL_AT];

  // A stalled result holds
  `GTRT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // One request in flight: no request is taken right after another
  `GTRT_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "back-to-back request taken")

  // An idle tracker has no active target
  `GTRT_ASSERT_IMP(a_idle_no_target, m_axis_tvalid && (r_phase == gtrt_pkg::PH_IDLE), r_target == '0, "idle with active target")

  // A refused dispatch never reports success
  `GTRT_ASSERT_IMP(a_full_not_ok, m_axis_tvalid && r_full, !r_ok, "table full with ok set")

endmodule

bind generation_tagged_request_tracker gtrt_checker #(
  .TARGET_BITS(TARGET_BITS),
  .GEN_BITS(GEN_BITS),
  .OUT_W(OUT_W)
) u_gtrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* sim/gtrt_tracker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtrt_tracker_checker
// Watches the request and response streams of the request tracker, keeps a
// shadow of its phase, target, generation and slot table, and compares
// every response field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
// Both streams are sampled on the falling edge. Inputs and outputs of the
// block only move on the rising edge, so a handshake seen here is the one
// that completes at the next rising edge. The shadow state is therefore
// current when the stimulus builds its next request at that edge.
// ----------------------------------------------------------------------------

module gtrt_tracker_checker #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [47:0] req_data_i,       // target_id, generation_tag
  input  logic [2:0]  req_user_i,       // req_type
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [55:0] rsp_data_i,       // ok, generation_now, phase_now,
                                        // active_target_now, table_full
  output int          fail_count_o,
  output int          outstanding_o,
  output logic [31:0] generation_o,
  output logic [15:0] active_target_o
);

  // Response layout, lowest field in the lowest bits
  typedef struct packed {
    logic        full;
    logic [15:0] target;
    logic [1:0]  phase;
    logic [31:0] generation;
    logic        ok;
  } tracker_rsp_t;

  // Shadow of the tracker state
  logic [1:0]  trk_phase;
  logic [31:0] trk_gen;
  logic [15:0] trk_active;
  logic        slot_busy [SLOTS];
  logic [15:0] slot_tgt  [SLOTS];
  logic [31:0] slot_gen  [SLOTS];

  // Predicted responses, oldest first
  tracker_rsp_t due_rsp [$];

  task automatic reset_tracker();
    trk_phase  = gtrt_pkg::PH_IDLE;
    trk_gen    = '0;
    trk_active = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_tgt[i]  = '0;
      slot_gen[i]  = '0;
    end
  endtask

  // Slot holding the target, -1 if none
  function automatic int slot_of(input logic [15:0] t);
    int s;
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && slot_busy[i] && slot_tgt[i] == t) s = i;
    return s;
  endfunction

  // Abandon the active request
  function automatic void drop_request();
    trk_gen    = trk_gen + 32'd1;
    trk_active = '0;
    trk_phase  = gtrt_pkg::PH_IDLE;
  endfunction

  // Apply one request to the shadow state and return the response it yields
  function automatic tracker_rsp_t apply_request(input logic [2:0]  kind,
                                                 input logic [15:0] t,
                                                 input logic [31:0] tag);
    tracker_rsp_t r;
    int           s;
    logic         ok;
    logic         full;
    ok   = 1'b0;
    full = 1'b0;
    case (kind)
      gtrt_pkg::REQ_SCHEDULE: begin
        trk_active = t;
        trk_phase  = gtrt_pkg::PH_SCHEDULED;
        trk_gen    = trk_gen + 32'd1;
        ok         = 1'b1;
      end
      gtrt_pkg::REQ_DISPATCH: begin
        if (trk_phase == gtrt_pkg::PH_SCHEDULED && tag == trk_gen && t == trk_active &&
            slot_of(t) < 0) begin
          // lowest free slot takes the request
          s = -1;
          for (int i = 0; i < SLOTS; i++)
            if (s < 0 && !slot_busy[i]) s = i;
          if (s < 0) begin
            full = 1'b1;
          end else begin
            slot_busy[s] = 1'b1;
            slot_tgt[s]  = t;
            slot_gen[s]  = tag;
            trk_phase    = gtrt_pkg::PH_AWAITING;
            ok           = 1'b1;
          end
        end
      end
      gtrt_pkg::REQ_EXPIRE: begin
        s = slot_of(t);
        if (s >= 0 && slot_gen[s] == tag) begin
          slot_busy[s] = 1'b0;
          if (trk_phase == gtrt_pkg::PH_AWAITING && t == trk_active && tag == trk_gen)
            drop_request();
          ok = 1'b1;
        end
      end
      gtrt_pkg::REQ_ACCEPT: begin
        // slot is freed even for a stale response
        s = slot_of(t);
        if (s >= 0) begin
          slot_busy[s] = 1'b0;
          if (trk_phase == gtrt_pkg::PH_AWAITING && t == trk_active &&
              slot_gen[s] == trk_gen) begin
            trk_phase = gtrt_pkg::PH_DISPLAYED;
            ok        = 1'b1;
          end
        end
      end
      gtrt_pkg::REQ_INVALIDATE: begin
        if (trk_phase != gtrt_pkg::PH_IDLE && t == trk_active) begin
          drop_request();
          ok = 1'b1;
        end
      end
      gtrt_pkg::REQ_REMOVE: begin
        s = slot_of(t);
        if (s >= 0) begin
          slot_busy[s] = 1'b0;
          ok           = 1'b1;
        end
        if (trk_active == t) begin
          drop_request();
          ok = 1'b1;
        end
      end
      default: ;  // unused kinds change nothing
    endcase
    r.ok         = ok;
    r.generation = trk_gen;
    r.phase      = trk_phase;
    r.target     = trk_active;
    r.full       = full;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  // Compare responses first: a request accepted at the same edge cannot
  // have produced one yet
  always @(negedge clk_i) begin : watch
    tracker_rsp_t want;
    tracker_rsp_t got;
    if (!rst_ni) begin
      reset_tracker();
      due_rsp.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got = tracker_rsp_t'(rsp_data_i[51:0]);
        if (due_rsp.size() == 0) begin
          $error("response %h with no request pending", rsp_data_i);
          fail_count_o++;
        end else begin
          want = due_rsp[0];
          due_rsp.delete(0);
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("generation_now", want.generation, got.generation);
          check_field("phase_now", 32'(want.phase), 32'(got.phase));
          check_field("active_target_now", 32'(want.target), 32'(got.target));
          check_field("table_full", 32'(want.full), 32'(got.full));
        end
      end
      if (req_valid_i && req_ready_i)
        due_rsp.insert(due_rsp.size(), apply_request(req_user_i, req_data_i[15:0],
                                                     req_data_i[47:16]));
    end
    outstanding_o   = due_rsp.size();
    generation_o    = trk_gen;
    active_target_o = trk_active;
  end

endmodule

/* sim/tb_generation_tagged_request_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generation_tagged_request_tracker
// Drives schedule/dispatch/expire/accept/invalidate/remove requests into the
// tracker with random gaps and output stalls; the checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
// A short directed part covers reset-state corner cases, a full slot table,
// stale responses and the displayed phase. The random part is mostly
// schedule-dispatch-response sequences on a small pool of targets, mixed
// with noise requests of every kind, unused kinds included.
// ----------------------------------------------------------------------------

module tb_generation_tagged_request_tracker;

  // Kinds the block does not define
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam int N_ITEMS      = 450;
  localparam int CALM_ITEMS   = 80;   // final stretch with no idling
  localparam int DRAIN_CYCLES = 40;
  localparam int LOG_DEPTH    = 16;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;    // target_id, generation_tag
  logic [2:0]  s_axis_tuser;    // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;    // ok, generation_now, phase_now,
                                // active_target_now, table_full

  int          fail_count;
  int          outstanding;
  logic [31:0] cur_generation;
  logic [15:0] cur_target;

  bit          idle_on = 1'b0;
  int          stall_left = 0;
  int          sent = 0;
  logic [47:0] dispatch_log [$];   // {tag, target} of recent dispatches

  always #5 clk_i = ~clk_i;

  generation_tagged_request_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gtrt_tracker_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (s_axis_tvalid),
    .req_ready_i     (s_axis_tready),
    .req_data_i      (s_axis_tdata),
    .req_user_i      (s_axis_tuser),
    .rsp_valid_i     (m_axis_tvalid),
    .rsp_ready_i     (m_axis_tready),
    .rsp_data_i      (m_axis_tdata),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .generation_o    (cur_generation),
    .active_target_o (cur_target)
  );

  // Response side: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one request, optionally after a gap, and wait for its handshake
  task automatic send_req(input logic [2:0] kind, input logic [15:0] tgt,
                          input logic [31:0] tag);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {tag, tgt};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == gtrt_pkg::REQ_DISPATCH) begin
      dispatch_log.insert(dispatch_log.size(), {tag, tgt});
      if (dispatch_log.size() > LOG_DEPTH) dispatch_log.delete(0);
    end
    sent++;
  endtask

  // Small target pool so slots collide and the table fills
  function automatic logic [15:0] pool_target();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'h8000;
      4:       return 16'h5555;
      5:       return 16'hAAAA;
      6:       return 16'h1234;
      7:       return 16'h00FF;
      8:       return 16'hFF00;
      9:       return 16'h0F0F;
      10:      return 16'h7FFF;
      default: return 16'h4000;
    endcase
  endfunction

  initial begin
    logic [15:0] t;
    logic [31:0] tag;
    logic [47:0] e;
    int          mode_until;
    int          sel;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle corner cases
    idle_on = 1'b1;
    send_req(gtrt_pkg::REQ_REMOVE, 16'h0000, 32'h0000_0000);      // target 0 matches idle
    send_req(gtrt_pkg::REQ_INVALIDATE, 16'h0000, 32'hFFFF_FFFF);  // refused while idle
    send_req(REQ_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF);

    // Fill every slot with an outstanding dispatch
    for (int i = 0; i < 8; i++) begin
      t = (i == 1) ? 16'hFFFF : i[15:0];
      send_req(gtrt_pkg::REQ_SCHEDULE, t, 32'hFFFF_FFFF);
      send_req(gtrt_pkg::REQ_DISPATCH, t, cur_generation);
    end
    send_req(gtrt_pkg::REQ_SCHEDULE, 16'h1234, 32'h0000_0000);
    send_req(gtrt_pkg::REQ_DISPATCH, 16'h1234, cur_generation);   // table full

    // Stale accept and a matching expire free slots
    send_req(gtrt_pkg::REQ_ACCEPT, 16'hFFFF, 32'h0000_0000);
    e = dispatch_log[0];
    send_req(gtrt_pkg::REQ_EXPIRE, e[15:0], e[47:16]);

    // Now the dispatch fits; accept it and invalidate the displayed request
    send_req(gtrt_pkg::REQ_DISPATCH, 16'h1234, cur_generation);
    send_req(gtrt_pkg::REQ_ACCEPT, 16'h1234, 32'hFFFF_FFFF);
    send_req(gtrt_pkg::REQ_INVALIDATE, 16'h1234, 32'h0000_0000);

    // Random part
    mode_until = 0;
    while (sent < N_ITEMS) begin
      if (sent >= mode_until) begin
        idle_on    = ($urandom_range(0, 3) != 0);
        mode_until = sent + $urandom_range(20, 60);
      end
      if (sent >= N_ITEMS - CALM_ITEMS) idle_on = 1'b0;

      if ($urandom_range(0, 9) < 7) begin
        // schedule, dispatch, then usually a response or a cancel
        t = ($urandom_range(0, 4) != 0) ? pool_target() : 16'($urandom);
        send_req(gtrt_pkg::REQ_SCHEDULE, t, $urandom);
        tag = cur_generation;
        if ($urandom_range(0, 9) == 0) tag = tag ^ (32'h1 << $urandom_range(0, 31));
        send_req(gtrt_pkg::REQ_DISPATCH, t, tag);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_req(gtrt_pkg::REQ_ACCEPT, t, $urandom);
          6:                send_req(gtrt_pkg::REQ_EXPIRE, t, cur_generation);
          7:                send_req(gtrt_pkg::REQ_INVALIDATE, t, $urandom);
          8:                send_req(gtrt_pkg::REQ_REMOVE, t, $urandom);
          default: ;        // leave it outstanding
        endcase
      end else begin
        // noise of any kind, with tags and targets that sometimes match
        t   = ($urandom_range(0, 1) != 0) ? pool_target() : 16'($urandom);
        tag = $urandom;
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
          tag = cur_generation;
        end else if (sel == 1 && dispatch_log.size() != 0) begin
          e   = dispatch_log[$urandom_range(0, dispatch_log.size() - 1)];
          t   = e[15:0];
          tag = e[47:16];
        end else if (sel == 2) begin
          t = cur_target;
        end
        send_req(3'($urandom_range(0, 7)), t, tag);
      end
    end

    // Drain and give the verdict
    idle_on = 1'b0;
    s_axis_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("generation_tagged_request_tracker regression: pass");
    else
      $display("generation_tagged_request_tracker regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("generation_tagged_request_tracker regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/gtrt_pkg.sv
sv/gtrt_ram.sv
sv/gtrt_scan.sv
sv/generation_tagged_request_tracker.sv
sv/gtrt_checker.sv
sim/gtrt_tracker_checker.sv
sim/tb_generation_tagged_request_tracker.sv
